/* hw/rtl/gww_pkg.sv */
// Shared types and constants of the greedy word-wrap layout block.
// Item payload structs, the controller/datapath command and status bundles.
// No dependencies.
package gww_pkg;

    // Default depth of the line store, in columns
    localparam int MAX_WIDTH_DEF = 64;

    // Input item: opcode plus one colored glyph
    typedef struct packed {
        logic       opcode;
        logic [7:0] glyph_char;
        logic [7:0] glyph_color;
    } in_item_t;

    // Result item: one glyph of an emitted line, or an empty-line marker
    typedef struct packed {
        logic [7:0] out_char;
        logic [7:0] out_color;
        logic       has_glyph;
        logic       line_last;
    } out_item_t;

    // Opcodes
    localparam logic OP_GLYPH = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    // What an accepted item asks of the line
    typedef enum logic [1:0] {
        ACT_NONE  = 2'd0,
        ACT_CLOSE = 2'd1,
        ACT_MOVE  = 2'd2
    } action_t;

    // Controller to datapath
    typedef struct packed {
        logic accept;      // take the item on the input channel
        logic emit_rd;     // read line store at the emit index
        logic emit_load;   // load the output register from the read data
        logic mark_load;   // load an empty-line marker into the output register
        logic copy_start;  // clear the index before the word move
        logic copy_rd;     // read the word source entry
        logic copy_wr;     // write the moved entry to its new place
    } gww_cmd_t;

    // Datapath to controller
    typedef struct packed {
        action_t act;        // action of the item now on the input channel
        logic    emit_zero;  // line to emit holds no glyph
        logic    emit_last;  // emit index is on the final glyph
        logic    is_move;    // a word move follows the emission
        logic    copy_done;  // all word entries moved
        logic    out_free;   // output register can take an item
    } gww_status_t;

endpackage

/* hw/rtl/gww_ctrl.sv */
// Controller of the greedy word-wrap layout block: accept, emit, word-move sequencing.
// Depends on gww_pkg.
module gww_ctrl
    import gww_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  gww_status_t status,
    output gww_cmd_t    cmd
);

    typedef enum logic [5:0] {
        S_IDLE    = 6'b000001,
        S_EMIT_RD = 6'b000010,
        S_EMIT_LD = 6'b000100,
        S_MARK    = 6'b001000,
        S_COPY_RD = 6'b010000,
        S_COPY_WR = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Only one item is in the works at a time
    assign s_ready = (state_reg == S_IDLE);

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    if (status.act != ACT_NONE) begin
                        state_next = S_EMIT_RD;
                    end
                end
            end
            S_EMIT_RD: begin
                if (status.emit_zero) begin
                    state_next = S_MARK;
                end else begin
                    cmd.emit_rd = 1'b1;
                    state_next  = S_EMIT_LD;
                end
            end
            S_EMIT_LD: begin
                if (status.out_free) begin
                    cmd.emit_load = 1'b1;
                    if (status.emit_last) begin
                        if (status.is_move) begin
                            cmd.copy_start = 1'b1;
                            state_next     = S_COPY_RD;
                        end else begin
                            state_next = S_IDLE;
                        end
                    end else begin
                        state_next = S_EMIT_RD;
                    end
                end
            end
            S_MARK: begin
                if (status.out_free) begin
                    cmd.mark_load = 1'b1;
                    if (status.is_move) begin
                        cmd.copy_start = 1'b1;
                        state_next     = S_COPY_RD;
                    end else begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_COPY_RD: begin
                if (status.copy_done) begin
                    state_next = S_IDLE;
                end else begin
                    cmd.copy_rd = 1'b1;
                    state_next  = S_COPY_WR;
                end
            end
            S_COPY_WR: begin
                cmd.copy_wr = 1'b1;
                state_next  = S_COPY_RD;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

/* hw/rtl/gww_datapath.sv */
// Datapath of the greedy word-wrap layout block: line store, layout registers,
// placement decision and output register. Depends on gww_pkg.
module gww_datapath
    import gww_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [6:0]  cfg_wr_data,
    input  in_item_t    s_item,
    input  gww_cmd_t    cmd,
    output gww_status_t status,
    input  logic        m_ready,
    output logic        m_valid,
    output out_item_t   m_item
);

    localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int CW = $clog2(MAX_WIDTH + 1);

    localparam logic [CW-1:0] WIDTH_MIN = CW'(2);
    localparam logic [CW-1:0] WIDTH_MAX = CW'(MAX_WIDTH);
    localparam logic [6:0]    CFG_MIN   = 7'd2;
    localparam logic [6:0]    CFG_MAX   = 7'(MAX_WIDTH);
    localparam logic [7:0]    CHAR_NL   = 8'h0A;
    localparam logic [7:0]    CHAR_SP   = 8'h20;
    localparam logic [7:0]    CHAR_TAB  = 8'h09;
    localparam logic [7:0]    CHAR_CR   = 8'h0D;

    typedef enum logic [1:0] {
        MODE_START   = 2'd0,
        MODE_FIRST   = 2'd1,
        MODE_BETWEEN = 2'd2,
        MODE_PROBE   = 2'd3
    } layout_mode_t;

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CHAR_SP) || (c >= CHAR_TAB && c <= CHAR_CR);
    endfunction

    // Line store, color in the high byte
    logic [15:0] line_store [MAX_WIDTH];
    logic [15:0] rdata_reg;

    logic [CW-1:0] width_reg,    width_next;
    logic [CW-1:0] fill_reg,     fill_next;
    logic [CW-1:0] mark_reg,     mark_next;
    layout_mode_t  mode_reg,     mode_next;
    logic [CW-1:0] emit_n_reg,   emit_n_next;
    logic [CW-1:0] base_reg,     base_next;
    logic [CW-1:0] copy_len_reg, copy_len_next;
    logic [CW-1:0] k_reg,        k_next;
    logic          is_move_reg,  is_move_next;
    logic          m_valid_reg,  m_valid_next;
    out_item_t     m_item_reg,   m_item_next;

    // Placement decision signals
    logic          blank;
    logic          null_glyph;
    logic          put_ok;
    logic [CW-1:0] put_fill;
    logic          full_put;
    logic          do_put;
    logic [CW-1:0] fill_after;
    action_t       act;
    layout_mode_t  mode_acc;
    logic [CW-1:0] mark_acc;
    logic [CW-1:0] mark_sel;
    logic [CW-1:0] mark_cut;
    logic [CW-1:0] move_raw;
    logic [CW-1:0] move_len;
    logic [CW-1:0] width_cfg;

    // Memory port signals
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [15:0]   wr_data;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [CW:0]   src_sum;
    logic [CW:0]   k_inc;
    logic          emit_last;
    logic          out_free;

    // Where the accepted glyph goes and what it does to the line
    always_comb begin
        blank      = is_blank(s_item.glyph_char);
        null_glyph = (s_item.glyph_char == 8'h00) && (s_item.glyph_color == 8'h00);
        put_ok     = (fill_reg < width_reg);
        put_fill   = put_ok ? fill_reg + CW'(1) : fill_reg;
        full_put   = (put_fill >= width_reg);
        do_put     = 1'b0;
        act        = ACT_NONE;
        mode_acc   = mode_reg;
        mark_acc   = mark_reg;
        mark_sel   = mark_reg;
        if (s_item.opcode == OP_FLUSH) begin
            act = ACT_CLOSE;
        end else if (null_glyph) begin
            act = ACT_NONE;
        end else if (s_item.glyph_char == CHAR_NL) begin
            act = ACT_CLOSE;
        end else begin
            case (mode_reg)
                MODE_START: begin
                    if (!blank) begin
                        do_put   = 1'b1;
                        mode_acc = MODE_FIRST;
                    end
                end
                MODE_FIRST: begin
                    do_put = 1'b1;
                    if (full_put) begin
                        act = ACT_CLOSE;
                    end else if (blank) begin
                        mode_acc = MODE_BETWEEN;
                    end
                end
                MODE_BETWEEN: begin
                    do_put = 1'b1;
                    if (blank) begin
                        if (full_put) begin
                            act = ACT_CLOSE;
                        end
                    end else begin
                        mark_acc = fill_reg;
                        mark_sel = fill_reg;
                        if (full_put) begin
                            act = ACT_MOVE;
                        end else begin
                            mode_acc = MODE_PROBE;
                        end
                    end
                end
                MODE_PROBE: begin
                    do_put = 1'b1;
                    if (blank) begin
                        if (full_put) begin
                            act = ACT_CLOSE;
                        end else begin
                            mode_acc = MODE_BETWEEN;
                        end
                    end else if (full_put) begin
                        act = ACT_MOVE;
                    end
                end
                default: begin
                    mode_acc = MODE_START;
                end
            endcase
        end
        fill_after = do_put ? put_fill : fill_reg;
        mark_cut   = (mark_sel > fill_after) ? fill_after : mark_sel;
        move_raw   = fill_after - mark_cut;
        move_len   = (move_raw > width_reg) ? width_reg : move_raw;
    end

    // Written width, saturated into the legal range
    always_comb begin
        if (cfg_wr_data < CFG_MIN) begin
            width_cfg = WIDTH_MIN;
        end else if (cfg_wr_data > CFG_MAX) begin
            width_cfg = WIDTH_MAX;
        end else begin
            width_cfg = cfg_wr_data[CW-1:0];
        end
    end

    // Emit and copy index arithmetic
    assign k_inc     = {1'b0, k_reg} + (CW+1)'(1);
    assign emit_last = (k_inc == {1'b0, emit_n_reg});
    assign src_sum   = {1'b0, base_reg} + {1'b0, k_reg};
    assign out_free  = !m_valid_reg || m_ready;

    // Next values of the layout and sequencing registers
    always_comb begin
        width_next    = width_reg;
        fill_next     = fill_reg;
        mark_next     = mark_reg;
        mode_next     = mode_reg;
        emit_n_next   = emit_n_reg;
        base_next     = base_reg;
        copy_len_next = copy_len_reg;
        k_next        = k_reg;
        is_move_next  = is_move_reg;
        if (cfg_wr_en) begin
            width_next = width_cfg;
        end
        if (cmd.accept) begin
            mark_next     = mark_acc;
            base_next     = mark_cut;
            copy_len_next = move_len;
            is_move_next  = (act == ACT_MOVE);
            k_next        = '0;
            case (act)
                ACT_CLOSE: begin
                    emit_n_next = fill_after;
                    fill_next   = '0;
                    mode_next   = MODE_START;
                end
                ACT_MOVE: begin
                    emit_n_next = mark_cut;
                    fill_next   = move_len;
                    mode_next   = MODE_FIRST;
                end
                default: begin
                    fill_next = fill_after;
                    mode_next = mode_acc;
                end
            endcase
        end
        if (cmd.emit_load || cmd.copy_wr) begin
            k_next = k_inc[CW-1:0];
        end
        if (cmd.copy_start) begin
            k_next = '0;
        end
    end

    // Output register
    always_comb begin
        m_valid_next = m_valid_reg;
        m_item_next  = m_item_reg;
        if (cmd.emit_load) begin
            m_valid_next          = 1'b1;
            m_item_next.out_char  = rdata_reg[7:0];
            m_item_next.out_color = rdata_reg[15:8];
            m_item_next.has_glyph = 1'b1;
            m_item_next.line_last = emit_last;
        end else if (cmd.mark_load) begin
            m_valid_next          = 1'b1;
            m_item_next.out_char  = '0;
            m_item_next.out_color = '0;
            m_item_next.has_glyph = 1'b0;
            m_item_next.line_last = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg   <= WIDTH_MAX;
            fill_reg    <= '0;
            mode_reg    <= MODE_START;
            is_move_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            width_reg   <= width_next;
            fill_reg    <= fill_next;
            mode_reg    <= mode_next;
            is_move_reg <= is_move_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        mark_reg     <= mark_next;
        emit_n_reg   <= emit_n_next;
        base_reg     <= base_next;
        copy_len_reg <= copy_len_next;
        k_reg        <= k_next;
        m_item_reg   <= m_item_next;
    end

    // Line store ports: one write, one registered read
    assign wr_en   = (cmd.accept && do_put && put_ok) || cmd.copy_wr;
    assign wr_addr = cmd.copy_wr ? k_reg[AW-1:0] : fill_reg[AW-1:0];
    assign wr_data = cmd.copy_wr ? rdata_reg : {s_item.glyph_color, s_item.glyph_char};
    assign rd_en   = cmd.emit_rd || cmd.copy_rd;
    assign rd_addr = cmd.copy_rd ? src_sum[AW-1:0] : k_reg[AW-1:0];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            line_store[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rdata_reg <= line_store[rd_addr];
        end
    end

    // Status to the controller
    always_comb begin
        status.act       = act;
        status.emit_zero = (emit_n_reg == '0);
        status.emit_last = emit_last;
        status.is_move   = is_move_reg;
        status.copy_done = (k_reg >= copy_len_reg);
        status.out_free  = out_free;
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

endmodule

/* hw/rtl/greedy_word_wrap_layout.sv */
// Top level of the greedy word-wrap layout block: joins controller and datapath.
// Depends on gww_pkg, gww_ctrl and gww_datapath.
//
//   channel   ports                          direction   carries
//   input     s_valid, s_ready, s_item       in          opcode and one colored glyph
//   result    m_valid, m_ready, m_item       out         glyph of a line or empty-line marker
//   config    cfg_wr_en, cfg_wr_data         in          line width, no handshake
//
// An item that places a glyph or is dropped is accepted without leaving the idle state.
// An item that closes a line is accepted, then each emitted glyph takes a registered read
// of the line store and a load of the output register; an empty line loads a marker.
// A word move then copies each moved glyph through the single line store read port.
// Stalls on m_ready hold the emission; the next item waits until the line is out and any
// word move is done. Reset is synchronous and active low; the line store needs no clearing.
module greedy_word_wrap_layout
    import gww_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr_en,
    input  logic [6:0] cfg_wr_data,
    input  logic       s_valid,
    output logic       s_ready,
    input  in_item_t   s_item,
    output logic       m_valid,
    input  logic       m_ready,
    output out_item_t  m_item
);

    gww_cmd_t    cmd;
    gww_status_t status;

    gww_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    gww_datapath #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_item      (s_item),
        .cmd         (cmd),
        .status      (status),
        .m_ready     (m_ready),
        .m_valid     (m_valid),
        .m_item      (m_item)
    );

endmodule
